// ----- rtl/min_priority_queue_core_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the min priority queue core
// Concurrent checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef MIN_PRIORITY_QUEUE_CORE_MACROS_SVH
`define MIN_PRIORITY_QUEUE_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define MPQ_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("min priority queue assertion failed");

// Next-cycle implication, disabled during reset.
`define MPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("min priority queue assertion failed");

`else

`define MPQ_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define MPQ_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/mpq_pkg.sv -----
// ---------------------------------------------------------------------------
// Min priority queue package
// Field widths, operation and status codes, and cell control type.
// ---------------------------------------------------------------------------
package mpq_pkg;

   localparam int DEFAULT_CAPACITY    = 64;
   localparam int DEFAULT_VALUE_WIDTH = 32;

   localparam int FUNC_WIDTH      = 2;
   localparam int FIELD_VALUE_WIDTH = 32;
   localparam int RSP_COUNT_WIDTH = 7;
   localparam int STATUS_WIDTH    = 2;

   localparam logic [FUNC_WIDTH-1:0] FUNC_PUSH = 2'd0;
   localparam logic [FUNC_WIDTH-1:0] FUNC_POP  = 2'd1;
   localparam logic [FUNC_WIDTH-1:0] FUNC_PEEK = 2'd2;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL  = 2'd2;

   // Operation broadcast to every cell of the chain.
   typedef struct packed {
      logic push;
      logic pop;
   } mpq_ctrl_type;

endpackage

// ----- rtl/mpq_cell.sv -----
// ---------------------------------------------------------------------------
// Min priority queue cell
// One slot of the sorted chain: holds one value, inserts or shifts.
// ---------------------------------------------------------------------------
module mpq_cell #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                     clock,
   input  mpq_pkg::mpq_ctrl_type    ctrl,
   input  logic [VALUE_WIDTH-1:0]   push_value,
   input  logic                     occupied,
   input  logic [VALUE_WIDTH-1:0]   left_value,
   input  logic                     left_greater,
   input  logic [VALUE_WIDTH-1:0]   right_value,
   output logic [VALUE_WIDTH-1:0]   value,
   output logic [VALUE_WIDTH-1:0]   value_next,
   output logic                     greater
);
   import mpq_pkg::*;

   logic [VALUE_WIDTH-1:0] value_ff;
   logic [VALUE_WIDTH-1:0] value_in;

   // An empty slot counts as holding a value above everything.
   assign greater = !occupied || ($signed(push_value) < $signed(value_ff));

   always_comb begin
      value_in = value_ff;
      if (ctrl.push && greater) begin
         // take the left neighbor's value when it moves right, else the new one
         value_in = left_greater ? left_value : push_value;
      end else if (ctrl.pop) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value      = value_ff;
   assign value_next = value_in;

endmodule

// ----- rtl/mpq_chain.sv -----
// ---------------------------------------------------------------------------
// Min priority queue chain
// Row of cells kept in ascending order, smallest value in cell zero.
// ---------------------------------------------------------------------------
module mpq_chain #(
   parameter int CAPACITY    = 64,
   parameter int VALUE_WIDTH = 32,
   parameter int COUNT_WIDTH = 7
) (
   input  logic                     clock,
   input  mpq_pkg::mpq_ctrl_type    ctrl,
   input  logic [VALUE_WIDTH-1:0]   push_value,
   input  logic [COUNT_WIDTH-1:0]   count,
   output logic [VALUE_WIDTH-1:0]   head_next
);
   import mpq_pkg::*;

   logic [VALUE_WIDTH-1:0] cell_value [CAPACITY];
   logic [VALUE_WIDTH-1:0] cell_next  [CAPACITY];
   logic                   cell_greater [CAPACITY];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VALUE_WIDTH-1:0] left_value;
      logic                   left_greater;
      logic [VALUE_WIDTH-1:0] right_value;
      logic                   occupied;

      if (i == 0) begin : g_first
         assign left_value   = push_value;
         assign left_greater = 1'b0;
      end else begin : g_inner
         assign left_value   = cell_value[i-1];
         assign left_greater = cell_greater[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_value = cell_value[i];
      end else begin : g_body
         assign right_value = cell_value[i+1];
      end

      assign occupied = COUNT_WIDTH'(i) < count;

      mpq_cell #(
         .VALUE_WIDTH (VALUE_WIDTH)
      ) u_cell (
         .clock        (clock),
         .ctrl         (ctrl),
         .push_value   (push_value),
         .occupied     (occupied),
         .left_value   (left_value),
         .left_greater (left_greater),
         .right_value  (right_value),
         .value        (cell_value[i]),
         .value_next   (cell_next[i]),
         .greater      (cell_greater[i])
      );
   end

   assign head_next = cell_next[0];

endmodule

// ----- rtl/min_priority_queue_core.sv -----
// ---------------------------------------------------------------------------
// Min priority queue core
// Bounded queue of signed values with push, pop-minimum and peek-minimum.
// ---------------------------------------------------------------------------
// A push or pop is settled at each request transfer by the row of
// CAPACITY cells, each comparing the pushed value with its own and
// shifting locally, and the result lands in an output register. A
// new request is taken whenever that register is empty or its result
// transfers in the same cycle, so one item per cycle is sustained.
// Every request yields exactly one result with the minimum after the
// operation (zero when empty), an empty flag, the element count (modulo 128)
// and a status. Pop or peek on an empty queue reports an empty error; a push
// into a full queue is dropped and reports full. Code 3 behaves as a peek.
// Stored values are VALUE_WIDTH bits wide: pushed values are sign-extended
// or truncated to that width, and the minimum is sign-extended or truncated
// back to 32 bits. Cell contents need no reset; count and valid are cleared.
// ---------------------------------------------------------------------------
`include "min_priority_queue_core_macros.svh"

module min_priority_queue_core #(
   parameter int CAPACITY    = mpq_pkg::DEFAULT_CAPACITY,
   parameter int VALUE_WIDTH = mpq_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_ready,
   input  logic        [mpq_pkg::FUNC_WIDTH-1:0]        req_func,
   input  logic signed [mpq_pkg::FIELD_VALUE_WIDTH-1:0] req_push_value,
   output logic                                       rsp_valid,
   input  logic                                       rsp_ready,
   output logic signed [mpq_pkg::FIELD_VALUE_WIDTH-1:0] rsp_min_value,
   output logic                                       rsp_is_empty,
   output logic        [mpq_pkg::RSP_COUNT_WIDTH-1:0]   rsp_count,
   output logic        [mpq_pkg::STATUS_WIDTH-1:0]      rsp_status
);
   import mpq_pkg::*;

   localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);

   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;

   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   logic signed [FIELD_VALUE_WIDTH-1:0] rsp_min_value_ff;
   logic signed [FIELD_VALUE_WIDTH-1:0] rsp_min_value_in;
   logic                           rsp_is_empty_ff;
   logic [RSP_COUNT_WIDTH-1:0]     rsp_count_ff;
   logic [STATUS_WIDTH-1:0]        rsp_status_ff;
   logic [STATUS_WIDTH-1:0]        rsp_status_in;

   logic                   req_transfer;
   logic                   is_full;
   logic                   is_empty;
   mpq_ctrl_type           ctrl;
   logic [VALUE_WIDTH-1:0] push_value;
   logic [VALUE_WIDTH-1:0] head_next;

   // Hold a request while an untaken result sits in the output register.
   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign req_transfer = req_valid && req_ready;

   assign is_full  = count_ff == COUNT_WIDTH'(CAPACITY);
   assign is_empty = count_ff == '0;

   // Sign-extend or truncate the pushed value to the stored width.
   assign push_value = VALUE_WIDTH'(req_push_value);

   // Decode the operation; drop pushes into a full queue and empty pops.
   always_comb begin
      ctrl          = '0;
      count_in      = count_ff;
      rsp_status_in = STATUS_OK;
      case (req_func)
         FUNC_PUSH: begin
            if (is_full) begin
               rsp_status_in = STATUS_FULL;
            end else begin
               ctrl.push = req_transfer;
               count_in  = count_ff + 1'b1;
            end
         end
         FUNC_POP: begin
            if (is_empty) begin
               rsp_status_in = STATUS_EMPTY;
            end else begin
               ctrl.pop = req_transfer;
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
            // peek, and the unused code that acts as one
            if (is_empty) begin
               rsp_status_in = STATUS_EMPTY;
            end
         end
      endcase
   end

   mpq_chain #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_chain (
      .clock      (clock),
      .ctrl       (ctrl),
      .push_value (push_value),
      .count      (count_ff),
      .head_next  (head_next)
   );

   // Report the head as it stands after the update, zero when empty.
   assign rsp_min_value_in = (count_in == '0) ? '0
                                              : FIELD_VALUE_WIDTH'($signed(head_next));

   // Advance the result register on a request, drop it once it transfers.
   assign rsp_valid_in = req_transfer || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_transfer) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_transfer) begin
         rsp_min_value_ff <= rsp_min_value_in;
         rsp_is_empty_ff  <= count_in == '0;
         rsp_count_ff     <= RSP_COUNT_WIDTH'(count_in);
         rsp_status_ff    <= rsp_status_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_min_value = rsp_min_value_ff;
   assign rsp_is_empty  = rsp_is_empty_ff;
   assign rsp_count     = rsp_count_ff;
   assign rsp_status    = rsp_status_ff;

   // Count never runs past the number of cells.
   `MPQ_ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= COUNT_WIDTH'(CAPACITY))

   // A push that fits grows the count by one.
   `MPQ_ASSERT_NEXT(a_push_grows, clock, reset,
      req_transfer && req_func == FUNC_PUSH && !is_full,
      count_ff == COUNT_WIDTH'($past(count_ff) + 1'b1))

   // A pop of a non-empty queue shrinks the count by one.
   `MPQ_ASSERT_NEXT(a_pop_shrinks, clock, reset,
      req_transfer && req_func == FUNC_POP && !is_empty,
      count_ff == COUNT_WIDTH'($past(count_ff) - 1'b1))

   // A full status is only reported when every cell is in use.
   `MPQ_ASSERT_IMPLIES(a_full_status, clock, reset,
      rsp_valid_ff && rsp_status_ff == STATUS_FULL, is_full)

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Min priority queue core testbench
// Drives push, pop and peek requests with random gaps and back-pressure,
// keeps its own sorted copy of the queue to predict every response, and
// compares each response transfer field by field against the oldest
// prediction. A short directed table runs first, then random sequences
// that fill, drain and mix operations.
// ---------------------------------------------------------------------------
module testbench;
   import mpq_pkg::*;

   localparam int CAPACITY          = DEFAULT_CAPACITY;
   localparam int RANDOM_ITEMS      = 1525;
   localparam int LONG_HOLD_CYCLES  = 300;
   localparam int WATCHDOG_LIMIT    = 2000;
   localparam int DRAIN_CYCLES      = 20;
   localparam int DIRECTED_COUNT    = 25;

   // Code 3 is not defined by the package; the core treats it as a peek.
   localparam logic [FUNC_WIDTH-1:0] FUNC_UNUSED = 2'd3;

   localparam logic signed [FIELD_VALUE_WIDTH-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [FIELD_VALUE_WIDTH-1:0] VALUE_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic signed [FIELD_VALUE_WIDTH-1:0] min_value;
      logic                                is_empty;
      logic        [RSP_COUNT_WIDTH-1:0]   count;
      logic        [STATUS_WIDTH-1:0]      status;
   } queue_result_type;

   typedef struct packed {
      logic        [FUNC_WIDTH-1:0]        func;
      logic signed [FIELD_VALUE_WIDTH-1:0] value;
      logic                                typed_in;
      queue_result_type                    result;
   } directed_row_type;

   // Rows with typed_in set carry their response; the rest use the predictor.
   localparam directed_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{FUNC_POP,    32'sd0,        1'b1, '{32'sd0,    1'b1, 7'd0, STATUS_EMPTY}},
      '{FUNC_PEEK,   VALUE_MAX,     1'b1, '{32'sd0,    1'b1, 7'd0, STATUS_EMPTY}},
      '{FUNC_UNUSED, -32'sd1,       1'b1, '{32'sd0,    1'b1, 7'd0, STATUS_EMPTY}},
      '{FUNC_PUSH,   VALUE_MAX,     1'b1, '{VALUE_MAX, 1'b0, 7'd1, STATUS_OK}},
      '{FUNC_PUSH,   VALUE_MIN,     1'b1, '{VALUE_MIN, 1'b0, 7'd2, STATUS_OK}},
      '{FUNC_PEEK,   32'sd0,        1'b1, '{VALUE_MIN, 1'b0, 7'd2, STATUS_OK}},
      '{FUNC_PUSH,   32'sd0,        1'b0, '0},
      '{FUNC_PUSH,   -32'sd1,       1'b0, '0},
      '{FUNC_PUSH,   -32'sd1,       1'b0, '0},
      '{FUNC_PUSH,   -32'sd1,       1'b0, '0},
      '{FUNC_POP,    32'sd5,        1'b0, '0},
      '{FUNC_POP,    32'sd0,        1'b0, '0},
      '{FUNC_UNUSED, VALUE_MIN,     1'b0, '0},
      '{FUNC_POP,    32'sd0,        1'b0, '0},
      '{FUNC_POP,    32'sd0,        1'b0, '0},
      '{FUNC_POP,    32'sd0,        1'b0, '0},
      '{FUNC_PEEK,   -32'sd1,       1'b0, '0},
      '{FUNC_POP,    32'sd0,        1'b1, '{32'sd0,    1'b1, 7'd0, STATUS_OK}},
      '{FUNC_POP,    32'sd0,        1'b1, '{32'sd0,    1'b1, 7'd0, STATUS_EMPTY}},
      '{FUNC_PUSH,   32'sh5555_5555, 1'b0, '0},
      '{FUNC_PUSH,   32'shAAAA_AAAA, 1'b0, '0},
      '{FUNC_PUSH,   32'sd1,        1'b0, '0},
      '{FUNC_POP,    32'sd0,        1'b0, '0},
      '{FUNC_POP,    32'sd0,        1'b0, '0},
      '{FUNC_POP,    32'sd0,        1'b1, '{32'sd0,    1'b1, 7'd0, STATUS_OK}}
   };

   logic                                clock          = 1'b0;
   logic                                reset          = 1'b1;
   logic                                req_valid      = 1'b0;
   logic                                req_ready;
   logic        [FUNC_WIDTH-1:0]        req_func       = FUNC_PEEK;
   logic signed [FIELD_VALUE_WIDTH-1:0] req_push_value = '0;
   logic                                rsp_valid;
   logic                                rsp_ready      = 1'b0;
   logic signed [FIELD_VALUE_WIDTH-1:0] rsp_min_value;
   logic                                rsp_is_empty;
   logic        [RSP_COUNT_WIDTH-1:0]   rsp_count;
   logic        [STATUS_WIDTH-1:0]      rsp_status;

   // Testbench copy of the queue contents, kept ascending.
   logic signed [FIELD_VALUE_WIDTH-1:0] sorted_values [$];
   queue_result_type                    pending_results [$];
   queue_result_type                    oldest_result;
   queue_result_type                    predicted;

   int error_count    = 0;
   int stalled_cycles = 0;
   int items_sent     = 0;
   bit idle_off       = 1'b0;
   bit long_hold_req  = 1'b0;

   min_priority_queue_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_min_value  (rsp_min_value),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_count      (rsp_count),
      .rsp_status     (rsp_status)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Apply one operation to the sorted copy and return the response it yields.
   function automatic queue_result_type predict_queue_op(
      input logic        [FUNC_WIDTH-1:0]        func,
      input logic signed [FIELD_VALUE_WIDTH-1:0] value
   );
      queue_result_type r;
      int               pos;
      r.status = STATUS_OK;
      if (func == FUNC_PUSH) begin
         if (sorted_values.size() >= CAPACITY) begin
            r.status = STATUS_FULL;
         end else begin
            pos = sorted_values.size();
            while (pos > 0 && value < sorted_values[pos-1]) pos--;
            sorted_values.insert(pos, value);
         end
      end else if (func == FUNC_POP) begin
         if (sorted_values.size() == 0) r.status = STATUS_EMPTY;
         else void'(sorted_values.pop_front());
      end else if (sorted_values.size() == 0) begin
         r.status = STATUS_EMPTY;
      end
      r.min_value = (sorted_values.size() > 0) ? sorted_values[0] : '0;
      r.is_empty  = (sorted_values.size() == 0);
      r.count     = RSP_COUNT_WIDTH'(sorted_values.size());
      return r;
   endfunction

   function automatic int draw_idle();
      return idle_off ? 0 : $urandom_range(0, 10);
   endfunction

   // Mix full-range values with clustered ones so equal keys show up often.
   function automatic logic signed [FIELD_VALUE_WIDTH-1:0] draw_value();
      case ($urandom_range(0, 4))
         0:       return $signed($urandom_range(0, 8)) - 32'sd4;
         1: begin
            case ($urandom_range(0, 3))
               0:       return VALUE_MIN;
               1:       return VALUE_MAX;
               2:       return -32'sd1;
               default: return 32'sd0;
            endcase
         end
         2:       return VALUE_MIN + $signed($urandom_range(0, 3));
         default: return $urandom;
      endcase
   endfunction

   // Hold off for a random gap, then offer one request until it transfers.
   task automatic transfer_request(
      input logic        [FUNC_WIDTH-1:0]        func,
      input logic signed [FIELD_VALUE_WIDTH-1:0] value
   );
      int gap;
      gap = draw_idle();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= func;
      req_push_value <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic issue_request(
      input logic        [FUNC_WIDTH-1:0]        func,
      input logic signed [FIELD_VALUE_WIDTH-1:0] value
   );
      transfer_request(func, value);
      pending_results.push_back(predict_queue_op(func, value));
      items_sent++;
   endtask

   // Drop valid and wait until every predicted response has transferred.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   function automatic logic [FUNC_WIDTH-1:0] draw_mixed_func();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) return FUNC_PUSH;
      if (pick < 85) return FUNC_POP;
      if (pick < 95) return FUNC_PEEK;
      return FUNC_UNUSED;
   endfunction

   // Response side: random stall before each transfer, plus one long hold-off
   // on request so the core fills up and backs up its request channel.
   initial begin : response_side
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else begin
            stall = draw_idle();
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Compare every response transfer with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("response transfer with no request outstanding");
            error_count++;
         end else begin
            oldest_result = pending_results.pop_front();
            if (rsp_min_value !== oldest_result.min_value) begin
               $error("min_value mismatch: expected %0d, actual %0d",
                      oldest_result.min_value, rsp_min_value);
               error_count++;
            end
            if (rsp_is_empty !== oldest_result.is_empty) begin
               $error("is_empty mismatch: expected %0b, actual %0b",
                      oldest_result.is_empty, rsp_is_empty);
               error_count++;
            end
            if (rsp_count !== oldest_result.count) begin
               $error("count mismatch: expected %0d, actual %0d",
                      oldest_result.count, rsp_count);
               error_count++;
            end
            if (rsp_status !== oldest_result.status) begin
               $error("status mismatch: expected %0d, actual %0d",
                      oldest_result.status, rsp_status);
               error_count++;
            end
         end
      end
   end

   // Count cycles without any transfer; end the run if the core hangs.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stalled_cycles <= 0;
      else
         stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin : request_side
      int sequence_index;
      int repeat_count;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed table: typed-in responses where obvious, predictor elsewhere.
      for (int row = 0; row < DIRECTED_COUNT; row++) begin
         transfer_request(DIRECTED_ROWS[row].func, DIRECTED_ROWS[row].value);
         predicted = predict_queue_op(DIRECTED_ROWS[row].func, DIRECTED_ROWS[row].value);
         pending_results.push_back(DIRECTED_ROWS[row].typed_in ?
                                   DIRECTED_ROWS[row].result : predicted);
         items_sent++;
      end

      sequence_index = 0;
      while (items_sent < DIRECTED_COUNT + RANDOM_ITEMS) begin
         idle_off = ($urandom_range(0, 3) == 0);

         if (sequence_index == 3) begin
            // Drain fully, then stall the response side while requests keep coming.
            wait_for_drain();
            long_hold_req = 1'b1;
            idle_off = 1'b1;
            repeat (40) issue_request(draw_mixed_func(), draw_value());
         end else if (sequence_index % 9 == 7) begin
            wait_for_drain();
         end

         case ($urandom_range(0, 5))
            0, 1: begin
               // Fill to capacity, then push into a full queue.
               while (sorted_values.size() < CAPACITY) issue_request(FUNC_PUSH, draw_value());
               repeat_count = $urandom_range(1, 3);
               repeat (repeat_count) issue_request(FUNC_PUSH, draw_value());
               if ($urandom_range(0, 1)) issue_request(FUNC_PEEK, $urandom);
            end
            2: begin
               // Drain to empty, then pop or peek on the empty queue.
               while (sorted_values.size() > 0)
                  issue_request(($urandom_range(0, 4) == 0) ? FUNC_PEEK : FUNC_POP, $urandom);
               repeat_count = $urandom_range(1, 3);
               repeat (repeat_count) issue_request(FUNC_WIDTH'($urandom_range(1, 3)), $urandom);
            end
            3, 4: begin
               repeat_count = $urandom_range(10, 60);
               repeat (repeat_count) issue_request(draw_mixed_func(), draw_value());
            end
            default: begin
               // Noise: any code, any value.
               repeat_count = $urandom_range(5, 15);
               repeat (repeat_count) issue_request(FUNC_WIDTH'($urandom_range(0, 3)), $urandom);
            end
         endcase
         sequence_index++;
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/mpq_pkg.sv
rtl/mpq_cell.sv
rtl/mpq_chain.sv
rtl/min_priority_queue_core.sv
verif/testbench.sv
